FILE: src/substring_occurrence_finder_core_assert.svh
// Assertion macros used by the RTL of the substring finder.
`ifndef SUBSTRING_OCCURRENCE_FINDER_CORE_ASSERT_SVH
`define SUBSTRING_OCCURRENCE_FINDER_CORE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define SOF_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// A condition that must hold whenever the antecedent holds.
`define SOF_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define SOF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sof_pkg.sv
package sof_pkg;

  // Width of the needle length register.
  localparam int unsigned LEN_W = 5;
  // Width of the position field on the result stream.
  localparam int unsigned POS_W = 32;

  typedef enum logic [1:0] {
    CFG_NEEDLE_LOW  = 2'd0,
    CFG_NEEDLE_HIGH = 2'd1,
    CFG_NEEDLE_LEN  = 2'd2,
    CFG_COUNT_MODE  = 2'd3
  } cfg_index_e;

  typedef enum logic {
    KIND_MATCH = 1'b0,
    KIND_END   = 1'b1
  } item_kind_e;

  // Settings of one window cell: whether it takes part and the needle byte it expects.
  typedef struct packed {
    logic       active;
    logic [7:0] nb;
  } cell_cfg_t;

  typedef struct packed {
    item_kind_e       kind;
    logic [POS_W-1:0] pos;
    logic             last;
  } result_t;

  // Up to two results are written into the output queue in one cycle.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } fifo_push_t;

  // A UTF-8 byte starts a character unless its top bits are 10.
  function automatic logic is_lead(logic [7:0] b);
    return b[7:6] != 2'b10;
  endfunction

endpackage

FILE: src/sof_cell.sv
module sof_cell import sof_pkg::*; (
  input  logic       clk_i,
  input  logic       shift_en_i,
  input  logic [7:0] byte_i,
  input  cell_cfg_t  cfg_i,
  output logic [7:0] byte_o,
  output logic       eq_o,
  output logic       lead_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      byte_q <= byte_i;
    end
  end

  // The compare looks at the byte that enters this cell on the current transfer.
  assign eq_o   = !cfg_i.active || (byte_i == cfg_i.nb);
  assign lead_o = cfg_i.active && is_lead(cfg_i.nb);
  assign byte_o = byte_q;

endmodule

FILE: src/sof_out_fifo.sv
module sof_out_fifo import sof_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fifo_push_t                   push_i,
  input  logic                         pop_i,
  output result_t                      head_o,
  output logic                         valid_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  // DEPTH must be a power of two so that the pointers wrap by themselves.
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  result_t         mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic [PW-1:0]   wr_next;

  assign wr_next = wr_ptr_q + PW'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(push_i.n);
    rd_ptr_d = pop_i ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q + CW'(push_i.n) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = count_q != '0;
  assign count_o = count_q;

endmodule

FILE: src/substring_occurrence_finder_core.sv
// Substring finder for a byte stream.
// Text enters on the s_axis channel, one byte per transfer in tdata, with tlast
// on the final byte of a text. Results leave on the m_axis channel: tuser says
// whether the item is a match or the end of the text, tdata carries the match
// start position or the total text length, and tlast marks the end item.
// The needle, its length and the position unit are for the user to set through
// the plain write port only while no text is in flight, which the block does
// not enforce. A needle length of zero disables matching. A text byte is taken
// in every cycle that s_axis_tready is high. The window is a row of byte cells
// that shift on each transfer and compare themselves against the needle in
// parallel, so a match is decided in the cycle of the transfer. A second stage
// registers the counts and flags, forms the position and writes the queue.
// Results pass through an eight-entry queue; s_axis_tready stays high while
// the queue is certain to hold two more results, which is the worst case of a
// match on the final byte. A stalled receiver fills the queue and then holds
// tready low until entries drain. Reset clears the needle settings, the
// window fill, the counters and the queue.
module substring_occurrence_finder_core import sof_pkg::*; #(
  parameter int unsigned NEEDLE_MAX    = 16,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // position
  output logic        m_axis_tuser,   // item_kind
  output logic        m_axis_tlast,   // final_item
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i
);

  localparam int unsigned FILL_W    = $clog2(NEEDLE_MAX + 1);
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned CW        = $clog2(OUT_DEPTH + 1);
  localparam int unsigned PB        = POSITION_BITS;

  // Configuration registers.
  logic [63:0]       needle_low_q, needle_high_q;
  logic [LEN_W-1:0]  needle_len_q;
  logic              count_mode_q;
  logic [LEN_W-1:0]  nchars_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_low_q  <= '0;
      needle_high_q <= '0;
      needle_len_q  <= '0;
      count_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_NEEDLE_LOW:  needle_low_q  <= cfg_wdata_i;
        CFG_NEEDLE_HIGH: needle_high_q <= cfg_wdata_i;
        CFG_NEEDLE_LEN:  needle_len_q  <= cfg_wdata_i[LEN_W-1:0];
        CFG_COUNT_MODE:  count_mode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Cell i holds the i-th newest byte and expects needle byte len-1-i.
  logic [15:0][7:0]          needle_bytes;
  cell_cfg_t                 cell_cfg [NEEDLE_MAX];
  logic [7:0]                cell_in  [NEEDLE_MAX];
  logic [7:0]                cell_out [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0]     cell_eq, cell_lead;

  assign needle_bytes = {needle_high_q, needle_low_q};

  for (genvar i = 0; i < NEEDLE_MAX; i++) begin : g_cell
    logic [LEN_W-1:0] diff;
    assign diff = needle_len_q - LEN_W'(i) - LEN_W'(1);
    assign cell_cfg[i].active = needle_len_q > LEN_W'(i);
    assign cell_cfg[i].nb     = needle_bytes[diff[3:0]];

    if (i == 0) begin : g_head
      assign cell_in[i] = s_axis_tdata;
    end else begin : g_link
      assign cell_in[i] = cell_out[i-1];
    end

    sof_cell u_cell (
      .clk_i      (clk_i),
      .shift_en_i (accept),
      .byte_i     (cell_in[i]),
      .cfg_i      (cell_cfg[i]),
      .byte_o     (cell_out[i]),
      .eq_o       (cell_eq[i]),
      .lead_o     (cell_lead[i])
    );
  end

  // The needle's character count only follows configuration, so it is registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nchars_q <= '0;
    end else begin
      nchars_q <= LEN_W'($countones(cell_lead));
    end
  end

  // Stream state: window fill and the two saturating counters.
  logic [FILL_W-1:0] fill_q, fill_d, fill_inc;
  logic [PB-1:0]     byte_cnt_q, byte_cnt_d, byte_inc;
  logic [PB-1:0]     char_cnt_q, char_cnt_d, char_inc;
  logic              hit;

  always_comb begin
    fill_inc = (fill_q == FILL_W'(NEEDLE_MAX)) ? fill_q : fill_q + FILL_W'(1);
    byte_inc = (byte_cnt_q == '1) ? byte_cnt_q : byte_cnt_q + PB'(1);
    char_inc = (char_cnt_q == '1 || !is_lead(s_axis_tdata)) ? char_cnt_q
                                                              : char_cnt_q + PB'(1);
    hit = (needle_len_q != '0) && (needle_len_q <= LEN_W'(NEEDLE_MAX)) &&
          (LEN_W'(fill_inc) >= needle_len_q) && (&cell_eq);
    // A match empties the window; the end of a text clears the whole stream state.
    fill_d     = (hit || s_axis_tlast) ? '0 : fill_inc;
    byte_cnt_d = s_axis_tlast ? '0 : byte_inc;
    char_cnt_d = s_axis_tlast ? '0 : char_inc;
  end

  // Second stage: the counts after this byte, the match flag and the end flag.
  logic          s2_valid_q, s2_hit_q, s2_last_q;
  logic [PB-1:0] s2_byte_q, s2_char_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      byte_cnt_q <= '0;
      char_cnt_q <= '0;
      s2_valid_q <= 1'b0;
      s2_hit_q   <= 1'b0;
      s2_last_q  <= 1'b0;
    end else begin
      s2_valid_q <= accept;
      if (accept) begin
        fill_q     <= fill_d;
        byte_cnt_q <= byte_cnt_d;
        char_cnt_q <= char_cnt_d;
        s2_hit_q   <= hit;
        s2_last_q  <= s_axis_tlast;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_byte_q <= byte_inc;
      s2_char_q <= char_inc;
    end
  end

  // The match start is the count minus the needle size in the chosen unit.
  // A saturated counter reports the maximum position.
  logic [PB-1:0]  sel_cnt, sub, match_pos;
  result_t        match_res, end_res;
  fifo_push_t     push;

  always_comb begin
    sel_cnt = count_mode_q ? s2_char_q : s2_byte_q;
    sub     = count_mode_q ? PB'(nchars_q) : PB'(needle_len_q);
    if (sel_cnt == '1) begin
      match_pos = sel_cnt;
    end else if (sel_cnt >= sub) begin
      match_pos = sel_cnt - sub;
    end else begin
      match_pos = '0;
    end

    match_res.kind = KIND_MATCH;
    match_res.pos  = POS_W'(match_pos);
    match_res.last = 1'b0;
    end_res.kind   = KIND_END;
    end_res.pos    = POS_W'(sel_cnt);
    end_res.last   = 1'b1;

    push.r0 = s2_hit_q ? match_res : end_res;
    push.r1 = end_res;
    push.n  = s2_valid_q ? (2'(s2_hit_q) + 2'(s2_last_q)) : 2'd0;
  end

  result_t        head;
  logic           head_valid;
  logic [CW-1:0]  fifo_count;
  logic [CW:0]    need;

  sof_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tvalid && m_axis_tready),
    .head_o  (head),
    .valid_o (head_valid),
    .count_o (fifo_count)
  );

  // Room is needed for what the second stage writes now plus two for a new byte.
  assign need          = (CW+1)'(fifo_count) + (CW+1)'(push.n) + (CW+1)'(2);
  assign s_axis_tready = need <= (CW+1)'(OUT_DEPTH);

  assign m_axis_tvalid = head_valid;
  assign m_axis_tdata  = head.pos;
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

`include "substring_occurrence_finder_core_assert.svh"

  `SOF_ASSERT_HOLDS(a_fifo_bound, fifo_count <= CW'(OUT_DEPTH), "output queue overflow")
  `SOF_ASSERT_NEXT(a_stage_follows, accept, s2_valid_q, "transfer did not reach stage two")
  `SOF_ASSERT_IMPLIES(a_hit_clears, s2_valid_q && s2_hit_q, fill_q == '0, "window kept after match")

endmodule
